[src/rtdg_pkg.sv]
// ----------------------------------------------------------------------------
// rtdg_pkg: shared types and constants of the go-to-goal controller
// Fixed-point formats, the arctangent table and the structs that pass
// between the top level and the bearing/distance pipeline.
// ----------------------------------------------------------------------------
package rtdg_pkg;

  // vectoring iterations, usable range 8 to 24
  localparam int CORDIC_STAGES = 14;
  localparam int ATAN_ENTRIES  = 24;

  // input register, cordic init register, one register per iteration, result register
  localparam int PIPE_DEPTH = CORDIC_STAGES + 3;

  // cordic datapath widths: offsets are 33 bits, growth and quadrant fold need 4 more
  localparam int CW = 37;
  localparam int ZW = 33;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
  localparam logic signed [17:0]   TWO_PI_Q13  = 18'sd51472;

  // configuration register indexes
  localparam logic [2:0] REG_GOAL_X          = 3'd0;
  localparam logic [2:0] REG_GOAL_Y          = 3'd1;
  localparam logic [2:0] REG_ANGLE_TOLERANCE = 3'd2;
  localparam logic [2:0] REG_ARRIVE_RADIUS   = 3'd3;
  localparam logic [2:0] REG_CRUISE_SPEED    = 3'd4;
  localparam logic [2:0] REG_TURN_LIMIT      = 3'd5;

  // phase codes on the command port
  localparam logic [1:0] CODE_ROTATE = 2'd0;
  localparam logic [1:0] CODE_DRIVE  = 2'd1;
  localparam logic [1:0] CODE_STOP   = 2'd2;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic        [20:0] arrive_radius;
  } pipe_cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] diff;     // wrapped heading error, Q3.13
    logic               outside;  // robot outside the arrive radius
  } pipe_res_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:       v = 33'sd843314856;
      1:       v = 33'sd497837829;
      2:       v = 33'sd263043836;
      3:       v = 33'sd133525158;
      4:       v = 33'sd67021686;
      5:       v = 33'sd33543515;
      6:       v = 33'sd16775850;
      7:       v = 33'sd8388437;
      8:       v = 33'sd4194282;
      9:       v = 33'sd2097149;
      10:      v = 33'sd1048575;
      11:      v = 33'sd524287;
      12:      v = 33'sd262143;
      13:      v = 33'sd131071;
      14:      v = 33'sd65535;
      15:      v = 33'sd32767;
      16:      v = 33'sd16383;
      17:      v = 33'sd8191;
      18:      v = 33'sd4095;
      19:      v = 33'sd2047;
      20:      v = 33'sd1023;
      21:      v = 33'sd511;
      22:      v = 33'sd255;
      23:      v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/rtdg_pipe.sv]
// ----------------------------------------------------------------------------
// rtdg_pipe: bearing and distance pipeline
// Offsets to the goal, a pipelined vectoring cordic for the bearing, the
// wrapped heading error and the arrive-radius test, one item per cycle while the output is taken.
// ----------------------------------------------------------------------------
module rtdg_pipe (
  input  logic               clk,
  input  logic               rst,
  input  rtdg_pkg::pipe_cfg_t cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtdg_pkg::pose_t    in_pose,
  output logic               out_valid,
  input  logic               out_take,
  output rtdg_pkg::pipe_res_t out_res
);
  import rtdg_pkg::*;

  // iterations at which the distance side work is done
  localparam int FAR_STAGE = 0;
  localparam int SQX_STAGE = 1;
  localparam int SQY_STAGE = 2;
  localparam int R2_STAGE  = 3;
  localparam int OUT_STAGE = 4;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 on_goal;
    logic signed [15:0]   hd;
    logic        [32:0]   adx;
    logic        [32:0]   ady;
    logic                 far;
    logic        [41:0]   sqx;
    logic        [41:0]   sqy;
    logic        [41:0]   r2;
    logic                 outside;
  } stage_t;

  // flow control: a stage loads when it is empty or its successor moves
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH:0]   adv;

  assign adv[PIPE_DEPTH] = out_take;
  for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[PIPE_DEPTH-1];

  // offsets to the goal
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [15:0] hd0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx  <= {cfg.goal_x[31], cfg.goal_x} - {in_pose.pos_x[31], in_pose.pos_x};
      dy  <= {cfg.goal_y[31], cfg.goal_y} - {in_pose.pos_y[31], in_pose.pos_y};
      hd0 <= in_pose.heading;
    end
  end

  // quadrant fold into the right half plane
  stage_t c_init;
  logic signed [CW-1:0] dxe;
  logic signed [CW-1:0] dye;

  always_comb begin
    dxe = {{(CW-33){dx[32]}}, dx};
    dye = {{(CW-33){dy[32]}}, dy};
    c_init = '0;
    if (!dx[32]) begin
      c_init.x = dxe;
      c_init.y = dye;
      c_init.z = '0;
    end else if (!dy[32]) begin
      c_init.x = dye;
      c_init.y = -dxe;
      c_init.z = HALF_PI_Q30;
    end else begin
      c_init.x = -dye;
      c_init.y = dxe;
      c_init.z = -HALF_PI_Q30;
    end
    c_init.on_goal = (dx == '0) && (dy == '0);
    c_init.hd      = hd0;
    c_init.adx     = dx[32] ? 33'(-dx) : 33'(dx);
    c_init.ady     = dy[32] ? 33'(-dy) : 33'(dy);
  end

  stage_t c_q    [CORDIC_STAGES+1];
  stage_t c_next [CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      c_q[0] <= c_init;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    always_comb begin
      c_next[i] = c_q[i];
      if (!c_q[i].y[CW-1]) begin
        c_next[i].x = c_q[i].x + ($signed(c_q[i].y) >>> i);
        c_next[i].y = c_q[i].y - ($signed(c_q[i].x) >>> i);
        c_next[i].z = c_q[i].z + atan_q30(i);
      end else begin
        c_next[i].x = c_q[i].x - ($signed(c_q[i].y) >>> i);
        c_next[i].y = c_q[i].y + ($signed(c_q[i].x) >>> i);
        c_next[i].z = c_q[i].z - atan_q30(i);
      end
      // squares only matter when both offsets are within the radius
      if (i == FAR_STAGE) begin
        c_next[i].far = (c_q[i].adx > {12'b0, cfg.arrive_radius})
                     || (c_q[i].ady > {12'b0, cfg.arrive_radius});
      end
      if (i == SQX_STAGE) begin
        c_next[i].sqx = {21'b0, c_q[i].adx[20:0]} * {21'b0, c_q[i].adx[20:0]};
      end
      if (i == SQY_STAGE) begin
        c_next[i].sqy = {21'b0, c_q[i].ady[20:0]} * {21'b0, c_q[i].ady[20:0]};
      end
      if (i == R2_STAGE) begin
        c_next[i].r2 = {21'b0, cfg.arrive_radius} * {21'b0, cfg.arrive_radius};
      end
      if (i == OUT_STAGE) begin
        c_next[i].outside = c_q[i].far
                         || (({1'b0, c_q[i].sqx} + {1'b0, c_q[i].sqy}) > {1'b0, c_q[i].r2});
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i+2]) begin
        c_q[i+1] <= c_next[i];
      end
    end
  end

  // round the angle to Q3.13 and wrap the error into (-pi, pi]
  stage_t               last;
  logic signed [ZW-1:0] z_rnd;
  logic signed [15:0]   bearing;
  logic signed [17:0]   diff_raw;
  logic signed [17:0]   diff_wrap;

  always_comb begin
    last     = c_q[CORDIC_STAGES];
    z_rnd    = last.z + ZW'(65536);
    bearing  = last.on_goal ? 16'sd0 : z_rnd[ZW-1:17];
    diff_raw = {{2{bearing[15]}}, bearing} - {{2{last.hd[15]}}, last.hd};
    if (diff_raw > PI_Q13) begin
      diff_wrap = diff_raw - TWO_PI_Q13;
    end else if (diff_raw <= -PI_Q13) begin
      diff_wrap = diff_raw + TWO_PI_Q13;
    end else begin
      diff_wrap = diff_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[PIPE_DEPTH-1]) begin
      out_res.diff    <= diff_wrap[15:0];
      out_res.outside <= last.outside;
    end
  end

endmodule

[src/rotate_then_drive_to_goal.sv]
// ----------------------------------------------------------------------------
// rotate_then_drive_to_goal: rotate-then-drive go-to-goal controller
// Turns toward a programmed goal, drives at cruise speed until inside the
// arrive radius, then stops. One speed command per valid pose tick.
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   -------  --------------------  -----------------------------------------
//   pose     in_valid / in_stall   pose_valid, pos_x, pos_y, heading
//   command  out_valid / out_stall linear_speed, angular_speed, phase
//   config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A new pose tick is taken every cycle while in_stall is low. Its command passes
// through the input register, the cordic init register, one register per
// iteration and the result register of the pipeline, then the output register.
// Ticks with pose_valid low are taken and dropped.
// A stalled command holds in the output register while empty pipeline stages
// keep filling; input stalls only once every stage is occupied.
// Reset puts the controller in the stopped phase with default gains.
//
module rotate_then_drive_to_goal (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               pose_valid,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [16:0] linear_speed,
  output logic signed [15:0] angular_speed,
  output logic        [1:0]  phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);
  import rtdg_pkg::*;

  typedef enum logic [2:0] {
    PH_ROTATE = 3'b001,
    PH_DRIVE  = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  // configuration registers
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic        [14:0] angle_tolerance;
  logic        [20:0] arrive_radius;
  logic        [16:0] cruise_speed;
  logic        [14:0] turn_limit;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x          <= '0;
      goal_y          <= '0;
      angle_tolerance <= 15'd82;
      arrive_radius   <= 21'd6554;
      cruise_speed    <= 17'd6554;
      turn_limit      <= 15'd8192;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOAL_X:          goal_x          <= cfg_data;
        REG_GOAL_Y:          goal_y          <= cfg_data;
        REG_ANGLE_TOLERANCE: angle_tolerance <= cfg_data[14:0];
        REG_ARRIVE_RADIUS:   arrive_radius   <= cfg_data[20:0];
        REG_CRUISE_SPEED:    cruise_speed    <= cfg_data[16:0];
        REG_TURN_LIMIT:      turn_limit      <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline
  pipe_cfg_t pcfg;
  pose_t     pose;
  pipe_res_t res;
  logic      pipe_ready;
  logic      res_valid;
  logic      out_take;
  logic      res_xfer;

  assign pcfg.goal_x        = goal_x;
  assign pcfg.goal_y        = goal_y;
  assign pcfg.arrive_radius = arrive_radius;
  assign pose.pos_x         = pos_x;
  assign pose.pos_y         = pos_y;
  assign pose.heading       = heading;

  assign in_stall = !pipe_ready;
  assign out_take = !out_valid || !out_stall;
  assign res_xfer = res_valid && out_take;

  rtdg_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (pcfg),
    .in_valid  (in_valid && pose_valid),
    .in_ready  (pipe_ready),
    .in_pose   (pose),
    .out_valid (res_valid),
    .out_take  (out_take),
    .out_res   (res)
  );

  // phase machine, resolved in arrival order as results leave the pipeline
  phase_t             phase_q;
  phase_t             phase_next;
  logic        [15:0] abs_diff;
  logic signed [16:0] diff_ext;
  logic signed [16:0] lim;
  logic signed [16:0] clamped;
  logic        [16:0] lin_next;
  logic signed [15:0] ang_next;
  logic        [1:0]  code_next;

  always_comb begin
    abs_diff = res.diff[15] ? 16'(-res.diff) : 16'(res.diff);
    diff_ext = {res.diff[15], res.diff};
    lim      = {2'b00, turn_limit};
    if (diff_ext > lim) begin
      clamped = lim;
    end else if (diff_ext < -lim) begin
      clamped = -lim;
    end else begin
      clamped = diff_ext;
    end

    phase_next = phase_q;
    lin_next   = '0;
    ang_next   = '0;
    unique case (phase_q)
      PH_ROTATE: begin
        if (abs_diff > {1'b0, angle_tolerance}) begin
          ang_next = clamped[15:0];
        end else begin
          phase_next = PH_DRIVE;
        end
      end
      PH_DRIVE: begin
        if (res.outside) begin
          lin_next = cruise_speed;
        end else begin
          phase_next = PH_STOP;
        end
      end
      default: phase_next = PH_STOP;
    endcase

    unique case (phase_next)
      PH_ROTATE: code_next = CODE_ROTATE;
      PH_DRIVE:  code_next = CODE_DRIVE;
      default:   code_next = CODE_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q <= PH_STOP;
    end else if (cfg_we && (cfg_index == REG_GOAL_X || cfg_index == REG_GOAL_Y)) begin
      phase_q <= PH_ROTATE;
    end else if (res_xfer) begin
      phase_q <= phase_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_xfer) begin
      linear_speed  <= lin_next;
      angular_speed <= ang_next;
      phase         <= code_next;
    end
  end

endmodule

[dv/tb_rotate_then_drive_to_goal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotate_then_drive_to_goal: self-checking bench of the go-to-goal controller
// A scoreboard predicts the speed command of every valid pose tick from its
// own copy of the goal, gains and phase, and checks each command transfer in
// order. Directed ticks cover the field extremes and corner cases. Random
// missions then arm a goal, turn toward it, drive in and stop, under bursty
// input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_rotate_then_drive_to_goal;
  import rtdg_pkg::*;

  localparam int DRAIN_CYCLES   = PIPE_DEPTH + 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POSE_TARGET    = 400;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // indexes with no register behind them
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // atan(2^-i), Q30
  localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
    524287, 262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef enum logic [1:0] {
    PH_ROTATE = CODE_ROTATE, PH_DRIVE = CODE_DRIVE, PH_STOP = CODE_STOP
  } phase_e;

  typedef struct {
    logic        [16:0] lin;
    logic signed [15:0] ang;
    phase_e             ph;
  } cmd_t;

  class steer_scoreboard;
    longint goal_x, goal_y;
    longint angle_tol, arrive_radius, cruise_speed, turn_limit;
    phase_e ph;
    cmd_t   pending_cmds[$];
    int     errors;

    function new();
      goal_x        = 0;
      goal_y        = 0;
      angle_tol     = 82;
      arrive_radius = 6554;
      cruise_speed  = 6554;
      turn_limit    = 8192;
      ph            = PH_STOP;
      errors        = 0;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_GOAL_X: begin
          goal_x = $signed(data);
          ph     = PH_ROTATE;
        end
        REG_GOAL_Y: begin
          goal_y = $signed(data);
          ph     = PH_ROTATE;
        end
        REG_ANGLE_TOLERANCE: angle_tol     = data & 32'h7FFF;
        REG_ARRIVE_RADIUS:   arrive_radius = data & 32'h1F_FFFF;
        REG_CRUISE_SPEED:    cruise_speed  = data & 32'h1_FFFF;
        REG_TURN_LIMIT:      turn_limit    = data & 32'h7FFF;
        default: ;
      endcase
    endfunction

    // vectoring cordic, bearing of (dx, dy) in Q3.13
    function longint goal_bearing(longint dx, longint dy);
      longint x, y, z, nx, ny;
      if (dx == 0 && dy == 0) return 0;
      if (dx >= 0) begin
        x = dx;  y = dy;  z = 0;
      end else if (dy >= 0) begin
        x = dy;  y = -dx; z = HALF_PI_Q30;
      end else begin
        x = -dy; y = dx;  z = -longint'(HALF_PI_Q30);
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + ATAN_Q30[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - ATAN_Q30[i];
        end
        x = nx;
        y = ny;
      end
      return (z + (longint'(1) << 16)) >>> 17;
    endfunction

    function void take_pose(logic pv, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [15:0] hd);
      longint dx, dy, diff, mag, adx, ady;
      bit     outside;
      cmd_t   c;
      if (pv !== 1'b1) return;
      dx    = goal_x - longint'(px);
      dy    = goal_y - longint'(py);
      c.lin = '0;
      c.ang = '0;
      case (ph)
        PH_ROTATE: begin
          diff = goal_bearing(dx, dy) - longint'(hd);
          while (diff > PI_Q13) diff = diff - TWO_PI_Q13;
          while (diff <= -longint'(PI_Q13)) diff = diff + TWO_PI_Q13;
          mag = (diff < 0) ? -diff : diff;
          if (mag > angle_tol) begin
            if (diff > turn_limit) diff = turn_limit;
            if (diff < -turn_limit) diff = -turn_limit;
            c.ang = diff[15:0];
          end else begin
            ph = PH_DRIVE;
          end
        end
        PH_DRIVE: begin
          adx = (dx < 0) ? -dx : dx;
          ady = (dy < 0) ? -dy : dy;
          // a single large offset already means outside, and keeps squares small
          if (adx > arrive_radius || ady > arrive_radius) outside = 1'b1;
          else outside = (adx * adx + ady * ady) > (arrive_radius * arrive_radius);
          if (outside) c.lin = cruise_speed[16:0];
          else ph = PH_STOP;
        end
        default: ph = PH_STOP;
      endcase
      c.ph = ph;
      pending_cmds.push_back(c);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_command(logic [16:0] lin, logic signed [15:0] ang, logic [1:0] ph_out);
      cmd_t e;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command lin %0d ang %0d phase %0d",
                                  lin, ang, ph_out));
        return;
      end
      e = pending_cmds.pop_front();
      if (lin !== e.lin)
        report_mismatch($sformatf("linear_speed %0d, expected %0d", lin, e.lin));
      if (ang !== e.ang)
        report_mismatch($sformatf("angular_speed %0d, expected %0d", ang, e.ang));
      if (ph_out !== e.ph)
        report_mismatch($sformatf("phase %0d, expected %0d", ph_out, e.ph));
    endtask
  endclass

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               pose_valid    = 1'b0;
  logic signed [31:0] pos_x         = '0;
  logic signed [31:0] pos_y         = '0;
  logic signed [15:0] heading       = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic        [16:0] linear_speed;
  logic signed [15:0] angular_speed;
  logic        [1:0]  phase;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic        [2:0]  cfg_index     = '0;
  logic        [31:0] cfg_data      = '0;

  steer_scoreboard sb = new();
  int  poses_sent  = 0;
  int  burst_left  = 0;
  int  idle_cycles = 0;
  bit  hold_req    = 1'b0;
  bit  holding     = 1'b0;

  rotate_then_drive_to_goal dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pose_valid    (pose_valid),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .linear_speed  (linear_speed),
    .angular_speed (angular_speed),
    .phase         (phase),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint rand_span(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // leaves cfg_valid high so back-to-back writes need no extra edge
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic send_pose(logic pv, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [15:0] hd);
    in_valid   <= 1'b1;
    pose_valid <= pv;
    pos_x      <= px;
    pos_y      <= py;
    heading    <= hd;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_pose(pv, px, py, hd);
    if (pv) poses_sent++;
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
    end
  endtask

  // dropped ticks give no command, so also let the pipeline run empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_mission(bit squeeze);
    int                 n, r;
    longint             span, off_x, off_y, rad;
    logic               pv;
    logic signed [31:0] px, py;
    logic signed [15:0] hd;
    wait_idle();
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 4);
      write_reg(REG_ANGLE_TOLERANCE,
                (r == 0) ? 0 : (r == 1) ? 25736 : $urandom_range(0, 600));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 4);
      write_reg(REG_ARRIVE_RADIUS,
                (r == 0) ? 0 : (r == 1) ? 1048576 : $urandom_range(1, 1 << 17));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 4);
      write_reg(REG_CRUISE_SPEED, (r == 0) ? 0 : (r == 1) ? 65536 : $urandom_range(0, 65536));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 4);
      write_reg(REG_TURN_LIMIT, (r == 0) ? 0 : (r == 1) ? 16384 : $urandom_range(0, 16384));
    end
    // any goal write arms the turn
    r = $urandom_range(0, 2);
    if (r != 1)
      write_reg(REG_GOAL_X, ($urandom_range(0, 4) == 0) ? $urandom : 32'(rand_span(1 << 24)));
    if (r != 0)
      write_reg(REG_GOAL_Y, ($urandom_range(0, 4) == 0) ? $urandom : 32'(rand_span(1 << 24)));
    cfg_valid <= 1'b0;

    span = longint'(1) << $urandom_range(4, 30);
    n    = squeeze ? 60 : $urandom_range(8, 30);
    if (squeeze) begin
      hold_req = 1'b1;
      do @(posedge clk); while (!holding);
    end
    for (int k = 0; k < n; k++) begin
      pv = 1'b1;
      r  = $urandom_range(0, 99);
      if (r < 16) begin
        pv = (r >= 8);
        px = $urandom;
        py = $urandom;
        hd = 16'($urandom);
      end else begin
        rad = sb.arrive_radius;
        if (sb.ph == PH_DRIVE) begin
          // a third of drive ticks land well inside the radius
          if ($urandom_range(0, 2) == 0) begin
            off_x = rand_span(rad / 2);
            off_y = rand_span(rad / 2);
          end else begin
            off_x = rand_span(rad * 3 + 16);
            off_y = rand_span(rad * 3 + 16);
          end
        end else begin
          off_x = rand_span(span);
          off_y = rand_span(span);
        end
        px = 32'(clip(sb.goal_x - off_x, Q_MIN, Q_MAX));
        py = 32'(clip(sb.goal_y - off_y, Q_MIN, Q_MAX));
        if (sb.ph == PH_ROTATE && $urandom_range(0, 9) < 4)
          hd = 16'(clip(sb.goal_bearing(sb.goal_x - px, sb.goal_y - py)
                        + rand_span(sb.angle_tol), -32768, 32767));
        else
          hd = 16'(rand_span(PI_Q13));
      end
      send_pose(pv, px, py, hd);
      if (!squeeze && k != n - 1) pace();
    end
  endtask

  // command monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_command(linear_speed, angular_speed, phase);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
        || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_rotate_then_drive_to_goal: done, errors");
      $finish;
    end
  end

  // receiver: stall segments of several kinds, plus one long hold-off on request
  initial begin
    int mode     = 0;
    int seg_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        holding   = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(5, 60);
      end
      seg_left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    int mission = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stopped after reset, and a dropped tick
    send_pose(1'b1, 32'sd0, 32'sd0, 16'sd0);
    send_pose(1'b0, $urandom, $urandom, 16'($urandom));

    // robot sitting on the goal: bearing zero, then arrived
    wait_idle();
    write_reg(REG_GOAL_X, 32'd0);
    write_reg(REG_GOAL_Y, 32'd0);
    cfg_valid <= 1'b0;
    send_pose(1'b1, 32'sd0, 32'sd0, 16'sd0);
    send_pose(1'b1, 32'sd0, 32'sd0, 16'sd0);

    // largest offsets, headings at and beyond +-pi, zero tolerance
    wait_idle();
    write_reg(REG_ANGLE_TOLERANCE, 32'd0);
    write_reg(REG_TURN_LIMIT, 32'd16384);
    write_reg(REG_GOAL_X, Q_MAX);
    write_reg(REG_GOAL_Y, Q_MIN);
    cfg_valid <= 1'b0;
    send_pose(1'b1, Q_MIN, Q_MAX, 16'sh8000);
    send_pose(1'b1, Q_MIN, Q_MAX, 16'sd32767);
    send_pose(1'b1, Q_MIN, Q_MAX, 16'sd25736);
    send_pose(1'b1, Q_MIN, Q_MAX, -16'sd25736);
    send_pose(1'b1, 32'sd0, 32'sd0, 16'sd0);

    // goal behind and to the lower left, zero turn limit
    wait_idle();
    write_reg(REG_TURN_LIMIT, 32'd0);
    write_reg(REG_GOAL_X, Q_MIN);
    write_reg(REG_GOAL_Y, 32'd0);
    cfg_valid <= 1'b0;
    send_pose(1'b1, Q_MAX, 32'sd0, 16'sd0);
    send_pose(1'b1, Q_MAX, Q_MAX, 16'sd0);

    // widest tolerance and radius, full cruise; corner and edge of the circle
    wait_idle();
    write_reg(REG_ANGLE_TOLERANCE, 32'd25736);
    write_reg(REG_ARRIVE_RADIUS, 32'd1048576);
    write_reg(REG_CRUISE_SPEED, 32'd65536);
    write_reg(REG_TURN_LIMIT, 32'd8192);
    write_reg(REG_GOAL_X, 32'd0);
    write_reg(REG_GOAL_Y, 32'd0);
    cfg_valid <= 1'b0;
    send_pose(1'b1, 32'sh4000_0000, 32'sd0, 16'sd0);
    send_pose(1'b1, 32'sh4000_0000, 32'sd0, 16'sd0);
    send_pose(1'b1, 32'sd1048576, 32'sd1048576, 16'sd0);
    send_pose(1'b1, 32'sd1048576, 32'sd0, 16'sd0);
    send_pose(1'b1, 32'sd1048576, 32'sd0, 16'sd0);

    // zero radius and zero cruise speed
    wait_idle();
    write_reg(REG_ARRIVE_RADIUS, 32'd0);
    write_reg(REG_CRUISE_SPEED, 32'd0);
    write_reg(REG_ANGLE_TOLERANCE, 32'd82);
    write_reg(REG_GOAL_X, 32'sd5 <<< 16);
    write_reg(REG_GOAL_Y, -(32'sd3 <<< 16));
    cfg_valid <= 1'b0;
    send_pose(1'b1, 32'sd5 <<< 16, -(32'sd3 <<< 16), 16'sd0);
    send_pose(1'b1, (32'sd5 <<< 16) + 32'sd1, -(32'sd3 <<< 16), 16'sd0);
    send_pose(1'b1, 32'sd5 <<< 16, -(32'sd3 <<< 16), 16'sd0);

    // unused register indexes must not arm a turn
    wait_idle();
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    cfg_valid <= 1'b0;
    send_pose(1'b1, $urandom, $urandom, 16'($urandom));

    while (poses_sent < POSE_TARGET) begin
      run_mission(mission == 3);
      mission++;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_rotate_then_drive_to_goal: done, clean");
    end else begin
      $display("tb_rotate_then_drive_to_goal: done, errors");
    end
    $finish;
  end

endmodule
